[rtl/stoi_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// stoi_pkg
// Shared types, character codes and helper functions for the streaming
// string-to-integer parser.
// ----------------------------------------------------------------------------
package stoi_pkg;

	// parse phase of the current string
	typedef enum logic [2:0] {
		PH_BLANK,
		PH_SIGNED,
		PH_HOLD,
		PH_HEXPFX,
		PH_DIGITS,
		PH_DONE
	} phase_t;

	localparam int unsigned ACC_W  = 64;
	localparam int unsigned MAC_W  = ACC_W + 4;
	localparam int unsigned VAL_W  = 32;
	localparam int unsigned ERR_W  = 9;
	localparam int unsigned CHAR_W = 8;

	// saturation cap of the magnitude, 2^63 + 1, two above the largest positive 64-bit signed value
	localparam logic [ACC_W-1:0] ACC_CAP = 64'h8000_0000_0000_0001;

	localparam logic [CHAR_W-1:0] CH_NUL    = 8'h00;
	localparam logic [CHAR_W-1:0] CH_SPACE  = 8'h20;
	localparam logic [CHAR_W-1:0] CH_DOLLAR = 8'h24;
	localparam logic [CHAR_W-1:0] CH_PLUS   = 8'h2B;
	localparam logic [CHAR_W-1:0] CH_MINUS  = 8'h2D;
	localparam logic [CHAR_W-1:0] CH_ZERO   = 8'h30;
	localparam logic [CHAR_W-1:0] CH_ONE    = 8'h31;
	localparam logic [CHAR_W-1:0] CH_NINE   = 8'h39;
	localparam logic [CHAR_W-1:0] CH_UP_A   = 8'h41;
	localparam logic [CHAR_W-1:0] CH_UP_F   = 8'h46;
	localparam logic [CHAR_W-1:0] CH_UP_X   = 8'h58;
	localparam logic [CHAR_W-1:0] CH_LO_A   = 8'h61;
	localparam logic [CHAR_W-1:0] CH_LO_F   = 8'h66;
	localparam logic [CHAR_W-1:0] CH_LO_X   = 8'h78;

	// marks a character that is no hex digit
	localparam logic [4:0] HV_NONE = 5'd16;

	function automatic logic is_dec(input logic [CHAR_W-1:0] c);
		return (c >= CH_ZERO) && (c <= CH_NINE);
	endfunction

	function automatic logic is_upper_hex(input logic [CHAR_W-1:0] c);
		return (c >= CH_UP_A) && (c <= CH_UP_F);
	endfunction

	// digit value 0..15, or HV_NONE
	function automatic logic [4:0] hex_val(input logic [CHAR_W-1:0] c);
		logic [4:0] v;
		if (is_dec(c)) begin
			v = 5'(c - CH_ZERO);
		end else if (is_upper_hex(c)) begin
			v = 5'(c - CH_UP_A) + 5'd10;
		end else if ((c >= CH_LO_A) && (c <= CH_LO_F)) begin
			v = 5'(c - CH_LO_A) + 5'd10;
		end else begin
			v = HV_NONE;
		end
		return v;
	endfunction

endpackage
`default_nettype wire

[rtl/string_to_integer_parser.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// string_to_integer_parser
// Streaming integer parser: one character per word in, one result word
// (value and error position) out on the word marked last.
// ----------------------------------------------------------------------------
//
//  channel  | valid / ready           | payload
//  ---------+-------------------------+------------------------------------
//  input    | char_valid / char_ready | char_code[7:0], last
//  result   | res_valid / res_ready   | value[31:0] signed, err_pos[8:0]
//
// one character word is taken every cycle while the input stage is not stalled; a
// word is registered in the input stage, and at the edge where it leaves the
// parse state updates and a last word loads the result register, so res_valid
// follows the last word through the input stage and the result register.
// the critical path is the 68-bit multiply-by-base add and saturation compare.
// arst_n clears the input stage, the parse state and the result valid.
// a waiting result only stalls the input stage while it holds a last word.
//
module string_to_integer_parser #(
	parameter int unsigned MAX_LEN = 255
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         char_valid,
	output logic                              char_ready,
	input  wire logic [stoi_pkg::CHAR_W-1:0]  char_code,
	input  wire logic                         last,
	output logic                              res_valid,
	input  wire logic                         res_ready,
	output logic signed [stoi_pkg::VAL_W-1:0] value,
	output logic [stoi_pkg::ERR_W-1:0]        err_pos
);
	import stoi_pkg::*;

	// position counts up to MAX_LEN, the finishing index reaches MAX_LEN + 1
	localparam int unsigned POS_W = $clog2(MAX_LEN + 2);

	// input stage
	logic              valid_s1;
	logic [CHAR_W-1:0] char_s1;
	logic              last_s1;
	logic              adv;

	// parse state
	phase_t            phase_q;
	logic              neg_q;
	logic [ACC_W-1:0]  acc_q;
	logic [POS_W-1:0]  pos_q;
	logic [POS_W-1:0]  bad_q;
	logic              hz_q;   // held prefix char was '0' (else '$')
	logic              hx_q;   // hex digits

	// next state
	phase_t            ph_n;
	logic              neg_n;
	logic [ACC_W-1:0]  acc_n;
	logic [POS_W-1:0]  pos_n;
	logic [POS_W-1:0]  bad_n;
	logic              hz_n;
	logic              hx_n;

	logic              term;
	logic              do_fin;
	logic [POS_W-1:0]  p_cur;
	logic [POS_W-1:0]  p_fin;
	logic [4:0]        hv;
	logic              dig_ok;
	logic [MAC_W-1:0]  acc_w;
	logic [MAC_W-1:0]  mac;

	// result register
	logic                     res_valid_q;
	logic signed [VAL_W-1:0]  value_q;
	logic [ERR_W-1:0]         err_q;
	logic [VAL_W-1:0]         value_n;

	// input stage moves on unless it holds a last word and the result is blocked
	assign adv        = valid_s1 && (!last_s1 || !res_valid_q || res_ready);
	assign char_ready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (char_ready) begin
			valid_s1 <= char_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (char_ready && char_valid) begin
			char_s1 <= char_code;
			last_s1 <= last;
		end
	end

	// digit accumulate: acc * base + digit, saturated at the cap
	assign hv     = hex_val(char_s1);
	assign dig_ok = hx_q ? (hv != HV_NONE) : is_dec(char_s1);
	assign acc_w  = MAC_W'(acc_q);
	assign mac    = (hx_q ? (acc_w << 4) : ((acc_w << 3) + (acc_w << 1))) + MAC_W'(hv);

	always_comb begin
		ph_n   = phase_q;
		neg_n  = neg_q;
		acc_n  = acc_q;
		pos_n  = pos_q;
		bad_n  = bad_q;
		hz_n   = hz_q;
		hx_n   = hx_q;
		p_cur  = pos_q + POS_W'(1);
		term   = (char_s1 == CH_NUL) || (pos_q >= POS_W'(MAX_LEN));
		do_fin = 1'b0;
		p_fin  = p_cur;
		if (phase_q != PH_DONE) begin
			if (term) begin
				do_fin = 1'b1;
			end else begin
				pos_n  = p_cur;
				do_fin = last_s1;
				p_fin  = p_cur + POS_W'(1);
				unique case (phase_q)
					PH_BLANK, PH_SIGNED: begin
						priority if ((phase_q == PH_BLANK) && (char_s1 == CH_SPACE)) begin
							ph_n = PH_BLANK;
						end else if ((phase_q == PH_BLANK) && (char_s1 == CH_PLUS)) begin
							ph_n = PH_SIGNED;
						end else if ((phase_q == PH_BLANK) && (char_s1 == CH_MINUS)) begin
							neg_n = 1'b1;
							ph_n  = PH_SIGNED;
						end else if ((char_s1 >= CH_ONE) && (char_s1 <= CH_NINE)) begin
							acc_n = ACC_W'(hv);
							hx_n  = 1'b0;
							ph_n  = PH_DIGITS;
						end else if (char_s1 == CH_ZERO) begin
							hz_n = 1'b1;
							ph_n = PH_HOLD;
						end else if (char_s1 == CH_DOLLAR) begin
							hz_n = 1'b0;
							ph_n = PH_HOLD;
						end else begin
							acc_n = '0;
							bad_n = p_cur;
							ph_n  = PH_DONE;
						end
					end
					PH_HOLD: begin
						priority if (hz_q && is_dec(char_s1)) begin
							acc_n = ACC_W'(hv);
							hx_n  = 1'b0;
							ph_n  = PH_DIGITS;
						end else if (hz_q && ((char_s1 == CH_LO_X) || (char_s1 == CH_UP_X))) begin
							ph_n = PH_HEXPFX;
						end else if (hz_q) begin
							// '0' then garbage points back at the '0'
							acc_n = '0;
							bad_n = pos_q;
							ph_n  = PH_DONE;
						end else if (is_dec(char_s1) || is_upper_hex(char_s1)) begin
							acc_n = ACC_W'(hv);
							hx_n  = 1'b1;
							ph_n  = PH_DIGITS;
						end else begin
							acc_n = '0;
							bad_n = p_cur;
							ph_n  = PH_DONE;
						end
					end
					PH_HEXPFX: begin
						if (hv != HV_NONE) begin
							acc_n = ACC_W'(hv);
							hx_n  = 1'b1;
							ph_n  = PH_DIGITS;
						end else begin
							acc_n = '0;
							bad_n = p_cur;
							ph_n  = PH_DONE;
						end
					end
					PH_DIGITS: begin
						if (dig_ok) begin
							acc_n = (mac > MAC_W'(ACC_CAP)) ? ACC_CAP : mac[ACC_W-1:0];
						end else begin
							bad_n = p_cur;
							ph_n  = PH_DONE;
						end
					end
					default: begin
						ph_n = phase_q;
					end
				endcase
			end
			// end of string
			if (do_fin) begin
				unique case (ph_n)
					PH_HOLD: begin
						if (hz_n) begin
							acc_n = '0;
							bad_n = '0;
						end else begin
							acc_n = '0;
							bad_n = p_fin;
						end
						ph_n = PH_DONE;
					end
					PH_DIGITS: begin
						bad_n = '0;
						ph_n  = PH_DONE;
					end
					PH_DONE: begin
						ph_n = PH_DONE;
					end
					default: begin
						acc_n = '0;
						bad_n = p_fin;
						ph_n  = PH_DONE;
					end
				endcase
			end
		end
	end

	// signed, saturated result: bit 63 set means magnitude at or above 2^63
	always_comb begin
		if (neg_n) begin
			value_n = acc_n[ACC_W-1] ? '0 : (~acc_n[VAL_W-1:0] + VAL_W'(1));
		end else begin
			value_n = acc_n[ACC_W-1] ? '1 : acc_n[VAL_W-1:0];
		end
	end

	// parse state, back to blanks after every last word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_BLANK;
			neg_q   <= 1'b0;
			acc_q   <= '0;
			pos_q   <= '0;
			bad_q   <= '0;
			hz_q    <= 1'b0;
			hx_q    <= 1'b0;
		end else if (adv) begin
			if (last_s1) begin
				phase_q <= PH_BLANK;
				neg_q   <= 1'b0;
				acc_q   <= '0;
				pos_q   <= '0;
				bad_q   <= '0;
				hz_q    <= 1'b0;
				hx_q    <= 1'b0;
			end else begin
				phase_q <= ph_n;
				neg_q   <= neg_n;
				acc_q   <= acc_n;
				pos_q   <= pos_n;
				bad_q   <= bad_n;
				hz_q    <= hz_n;
				hx_q    <= hx_n;
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (adv && last_s1) begin
			res_valid_q <= 1'b1;
		end else if (res_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && last_s1) begin
			value_q <= signed'(value_n);
			err_q   <= ERR_W'(bad_n);
		end
	end

	assign res_valid = res_valid_q;
	assign value     = value_q;
	assign err_pos   = err_q;

	// a last word always leaves a result and a fresh parse state behind
	a_last_result: assert property (@(posedge clk) disable iff (!arst_n)
		adv && last_s1 |=> res_valid_q && (phase_q == PH_BLANK) && (pos_q == '0))
		else $error("last word did not produce a result or reset the parse");

	// accumulator never passes the saturation cap
	a_acc_cap: assert property (@(posedge clk) disable iff (!arst_n)
		acc_q <= ACC_CAP)
		else $error("accumulator above saturation cap");

	// a reported error position lies within the string or at its terminator
	a_err_range: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q |-> (err_q <= ERR_W'(MAX_LEN + 1)))
		else $error("error position beyond terminator");

	// position only moves while a word advances
	a_pos_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> $stable(pos_q) && $stable(phase_q))
		else $error("parse state changed without a word");

endmodule
`default_nettype wire
